// ===== hdl/gcs_pkg.sv =====
package gcs_pkg;

	// Grid geometry
	localparam int ROW_COUNT = 64;
	localparam int ROW_BITS  = 64;
	localparam int ROW_W     = $clog2(ROW_COUNT);
	localparam int COL_W     = $clog2(ROW_BITS);

	// Field widths of the stream payloads
	localparam int BITS_W    = 64;
	localparam int INDEX_W   = 6;
	localparam int TDATA_W   = 72;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PASS_COUNT  = 2'd0,
		CFG_CLEAR_BELOW = 2'd1,
		CFG_SET_ABOVE   = 2'd2
	} cfg_reg_t;

	// Update rule thresholds, handed to the cell unit
	typedef struct packed {
		logic [CFG_W-1:0] clear_below;
		logic [CFG_W-1:0] set_above;
	} thresh_t;

	// Eight neighbors of the cell under update
	typedef struct packed {
		logic up_left;
		logic up;
		logic up_right;
		logic left;
		logic right;
		logic down_left;
		logic down;
		logic down_right;
	} nbr_t;

endpackage

// ===== hdl/gcs_cell_unit.sv =====
module gcs_cell_unit
	import gcs_pkg::*;
(
	input  nbr_t    nbr,
	input  logic    cur,
	input  thresh_t thresh,
	output logic    nxt
);

	logic [7:0]       nbr_vec;
	logic [CFG_W-1:0] wall_cnt;

	assign nbr_vec = nbr;

	always_comb begin
		wall_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			wall_cnt = wall_cnt + CFG_W'(nbr_vec[i]);
		end
	end

	// Set wins over clear when both thresholds are met
	always_comb begin
		nxt = cur;
		if (wall_cnt < thresh.clear_below) begin
			nxt = 1'b0;
		end
		if (wall_cnt > thresh.set_above) begin
			nxt = 1'b1;
		end
	end

endmodule

// ===== hdl/grid_cellular_smoothing.sv =====
// Channel  Direction  Payload
// s_*      in         tdata: row_bits[63:0], row_index[69:64], zero pad; tlast: last
// m_*      out        tdata: out_bits[63:0], out_index[69:64], zero pad; tlast: out_last
// cfg_*    in         cfg_index: register, cfg_data: value (pass_count, clear_below, set_above)
//
// A row item without tlast is stored. An item with tlast is stored too and starts the run:
// each pass walks the interior rows (reads of the rows above, at and below, one cell per cycle
// through the single cell unit over the interior columns, one write back), then the ROW_COUNT
// rows are read out in turn, each held on m_* until m_tready takes it. The single memory
// read port and the shared cell unit serialize this work. s_tready is low for the whole run.
// Reset clears the sequencer and loads the register defaults; the grid is not cleared.
module grid_cellular_smoothing
	import gcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // row_bits[63:0], row_index[69:64]
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // out_bits[63:0], out_index[69:64]
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_RD_ABOVE = 10'b0000000010,
		ST_RD_MID   = 10'b0000000100,
		ST_RD_BELOW = 10'b0000001000,
		ST_RD_LAST  = 10'b0000010000,
		ST_CELL     = 10'b0000100000,
		ST_WB       = 10'b0001000000,
		ST_EM_RD    = 10'b0010000000,
		ST_EM_CAP   = 10'b0100000000,
		ST_EM_WAIT  = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  pass_count_q;
	logic [CFG_W-1:0]  clear_below_q;
	logic [CFG_W-1:0]  set_above_q;
	logic [CFG_W-1:0]  passes_done_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;

	logic [ROW_BITS-1:0] grid_mem [ROW_COUNT];
	logic [ROW_BITS-1:0] rd_data_q;
	logic [ROW_W-1:0]    rd_addr;
	logic                wr_en;
	logic [ROW_W-1:0]    wr_addr;
	logic [ROW_BITS-1:0] wr_data;

	logic [ROW_BITS-1:0] above_q;
	logic [ROW_BITS-1:0] mid_q;
	logic [ROW_BITS-1:0] below_q;

	logic [ROW_BITS-1:0] out_bits_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic                out_last_q;
	logic                m_tvalid_q;

	logic                s_fire;
	logic                m_fire;
	logic                row_in_range;
	logic [ROW_W-1:0]    in_row;
	logic [COL_W-1:0]    col_m1;
	logic [COL_W-1:0]    col_p1;
	nbr_t                nbr;
	thresh_t             thresh;
	logic                cell_nxt;
	logic [CFG_W-1:0]    passes_inc;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_fire    = s_tvalid && s_tready;
	assign m_fire    = m_tvalid_q && m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(TDATA_W-BITS_W-INDEX_W){1'b0}}, out_index_q, BITS_W'(out_bits_q)};

	assign row_in_range = (32'(s_tdata[BITS_W +: INDEX_W]) < ROW_COUNT);
	assign in_row       = s_tdata[BITS_W +: ROW_W];
	assign passes_inc   = passes_done_q + 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q  <= CFG_W'(4);
			clear_below_q <= CFG_W'(4);
			set_above_q   <= CFG_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PASS_COUNT:  pass_count_q  <= cfg_data;
				CFG_CLEAR_BELOW: clear_below_q <= cfg_data;
				CFG_SET_ABOVE:   set_above_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thresh.clear_below = clear_below_q;
	assign thresh.set_above   = set_above_q;

	// Grid memory: one write port, one registered read port
	always_comb begin
		case (state_q)
			ST_RD_ABOVE: rd_addr = row_q - 1'b1;
			ST_RD_BELOW: rd_addr = row_q + 1'b1;
			default:     rd_addr = row_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = mid_q;
		if (state_q == ST_WB) begin
			wr_en = 1'b1;
		end else if (s_fire && row_in_range) begin
			wr_en   = 1'b1;
			wr_addr = in_row;
			wr_data = s_tdata[ROW_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= grid_mem[rd_addr];
	end

	// Neighborhood of the current cell; mid_q already holds cells updated this row
	assign col_m1 = col_q - 1'b1;
	assign col_p1 = col_q + 1'b1;

	assign nbr.up_left    = above_q[col_m1];
	assign nbr.up         = above_q[col_q];
	assign nbr.up_right   = above_q[col_p1];
	assign nbr.left       = mid_q[col_m1];
	assign nbr.right      = mid_q[col_p1];
	assign nbr.down_left  = below_q[col_m1];
	assign nbr.down       = below_q[col_q];
	assign nbr.down_right = below_q[col_p1];

	gcs_cell_unit u_cell (
		.nbr    (nbr),
		.cur    (mid_q[col_q]),
		.thresh (thresh),
		.nxt    (cell_nxt)
	);

	// Row window registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD_MID:   above_q <= rd_data_q;
			ST_RD_BELOW: mid_q   <= rd_data_q;
			ST_RD_LAST:  below_q <= rd_data_q;
			ST_CELL:     mid_q[col_q] <= cell_nxt;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_EM_CAP) begin
			out_bits_q  <= rd_data_q;
			out_index_q <= INDEX_W'(row_q);
			out_last_q  <= (row_q == ROW_W'(ROW_COUNT - 1));
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			passes_done_q <= '0;
			row_q         <= '0;
			col_q         <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire && s_tlast) begin
						passes_done_q <= '0;
						if (pass_count_q == '0) begin
							row_q   <= '0;
							state_q <= ST_EM_RD;
						end else begin
							row_q   <= ROW_W'(1);
							state_q <= ST_RD_ABOVE;
						end
					end
				end
				ST_RD_ABOVE: state_q <= ST_RD_MID;
				ST_RD_MID:   state_q <= ST_RD_BELOW;
				ST_RD_BELOW: state_q <= ST_RD_LAST;
				ST_RD_LAST: begin
					col_q   <= COL_W'(1);
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					if (col_q == COL_W'(ROW_BITS - 2)) begin
						state_q <= ST_WB;
					end else begin
						col_q <= col_p1;
					end
				end
				ST_WB: begin
					if (row_q == ROW_W'(ROW_COUNT - 2)) begin
						passes_done_q <= passes_inc;
						if (passes_inc == pass_count_q) begin
							row_q   <= '0;
							state_q <= ST_EM_RD;
						end else begin
							row_q   <= ROW_W'(1);
							state_q <= ST_RD_ABOVE;
						end
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= ST_RD_ABOVE;
					end
				end
				ST_EM_RD: state_q <= ST_EM_CAP;
				ST_EM_CAP: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_EM_WAIT;
				end
				ST_EM_WAIT: begin
					if (m_fire) begin
						m_tvalid_q <= 1'b0;
						if (row_q == ROW_W'(ROW_COUNT - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_EM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result is only presented while the emit step waits for it to be taken
	a_valid_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == ST_EM_WAIT))
		else $error("m_tvalid outside emit wait");

	// No new row is taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while output pending");

	// Cell walk stays on interior columns
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> (col_q >= COL_W'(1) && col_q <= COL_W'(ROW_BITS - 2)))
		else $error("column walk left the interior");

	// Final write back of the final pass hands over to emitting row zero
	a_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && row_q == ROW_W'(ROW_COUNT - 2) && passes_inc == pass_count_q)
		|=> (state_q == ST_EM_RD && row_q == '0))
		else $error("last pass did not start emit");

endmodule
